// ===== src/tmwg_pkg.sv =====
package tmwg_pkg;

  // Default sizes of the level and timer datapaths.
  localparam int LEVEL_BITS_DEF = 8;
  localparam int TIMER_BITS_DEF = 16;

  // Configuration register widths.
  localparam int MODE_BITS     = 2;
  localparam int AMP_BITS      = 8;
  localparam int LIMIT_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESCALE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 2'd3;

  // Waveform selection codes.
  localparam logic [MODE_BITS-1:0] MODE_SQUARE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SAWTOOTH = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_TRIANGLE = 2'd2;

  // Reset value of the amplitude register.
  localparam logic [AMP_BITS-1:0] AMP_RESET = 8'd255;

  // Current configuration, as seen by the timer and the wave shaper.
  typedef struct packed {
    logic [MODE_BITS-1:0]  wave_mode;
    logic [AMP_BITS-1:0]   amplitude;
    logic [LIMIT_BITS-1:0] prescale;
    logic [LIMIT_BITS-1:0] period;
  } cfg_t;

endpackage

// ===== src/tmwg_in_if.sv =====
interface tmwg_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink (input valid, input gate, output ready);
endinterface

// ===== src/tmwg_out_if.sv =====
interface tmwg_out_if #(
  parameter int LEVEL_BITS = tmwg_pkg::LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  stepped;

  modport source (output valid, output level, output stepped, input ready);
  modport sink (input valid, input level, input stepped, output ready);
endinterface

// ===== src/tmwg_cfg_regs.sv =====
module tmwg_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tmwg_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [tmwg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tmwg_pkg::cfg_t                     cfg
);
  import tmwg_pkg::*;

  cfg_t regs;

  // Register file; each write takes the low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wave_mode <= MODE_SQUARE;
      regs.amplitude <= AMP_RESET;
      regs.prescale  <= '0;
      regs.period    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WAVE_MODE: regs.wave_mode <= cfg_data[MODE_BITS-1:0];
        REG_AMPLITUDE: regs.amplitude <= cfg_data[AMP_BITS-1:0];
        REG_PRESCALE:  regs.prescale  <= cfg_data[LIMIT_BITS-1:0];
        REG_PERIOD:    regs.period    <= cfg_data[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== src/tmwg_timer.sv =====
module tmwg_timer #(
  parameter int TIMER_BITS = tmwg_pkg::TIMER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  tmwg_pkg::cfg_t cfg,
  output logic           period_wrap
);
  import tmwg_pkg::*;

  logic [TIMER_BITS-1:0] prescale_count;
  logic [TIMER_BITS-1:0] prescale_count_next;
  logic [TIMER_BITS-1:0] period_count;
  logic [TIMER_BITS-1:0] period_count_next;

  logic [TIMER_BITS+LIMIT_BITS-1:0] pre_wide;
  logic [TIMER_BITS+LIMIT_BITS-1:0] per_wide;
  logic [TIMER_BITS-1:0]            pre_lim;
  logic [TIMER_BITS-1:0]            per_lim;
  logic                             pre_wrap;

  // Limits are compared at the timer width.
  assign pre_wide = {{TIMER_BITS{1'b0}}, cfg.prescale};
  assign per_wide = {{TIMER_BITS{1'b0}}, cfg.period};
  assign pre_lim  = pre_wide[TIMER_BITS-1:0];
  assign per_lim  = per_wide[TIMER_BITS-1:0];

  // A counter at or above its limit wraps to zero on its next advance.
  assign pre_wrap    = (prescale_count >= pre_lim);
  assign period_wrap = advance && pre_wrap && (period_count >= per_lim);

  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    if (advance) begin
      if (pre_wrap) begin
        prescale_count_next = '0;
        if (period_count >= per_lim) begin
          period_count_next = '0;
        end else begin
          period_count_next = period_count + 1'b1;
        end
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
    end else begin
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
    end
  end

endmodule

// ===== src/tmwg_shaper.sv =====
module tmwg_shaper #(
  parameter int LEVEL_BITS = tmwg_pkg::LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  period_wrap,
  input  logic                  gate,
  input  tmwg_pkg::cfg_t        cfg,
  output logic [LEVEL_BITS-1:0] level_next,
  output logic                  step
);
  import tmwg_pkg::*;

  logic [LEVEL_BITS-1:0] out_level;
  logic                  rising;
  logic                  rising_next;

  logic [LEVEL_BITS+AMP_BITS-1:0] amp_wide;
  logic [LEVEL_BITS-1:0]          amp;
  logic [LEVEL_BITS-1:0]          level_up;
  logic [LEVEL_BITS-1:0]          level_down;
  logic                           mode_known;

  // Amplitude is taken at the level width.
  assign amp_wide = {{LEVEL_BITS{1'b0}}, cfg.amplitude};
  assign amp      = amp_wide[LEVEL_BITS-1:0];

  assign level_up   = out_level + 1'b1;
  assign level_down = out_level - 1'b1;

  // The unused mode code never steps.
  assign mode_known = (cfg.wave_mode == MODE_SQUARE) || (cfg.wave_mode == MODE_SAWTOOTH)
                   || (cfg.wave_mode == MODE_TRIANGLE);
  assign step = period_wrap && gate && mode_known;

  // One waveform step per period wrap while the gate is high and the mode is known.
  always_comb begin
    level_next  = out_level;
    rising_next = rising;
    if (step) begin
      case (cfg.wave_mode)
        MODE_SQUARE: begin
          level_next = (out_level == '0) ? amp : '0;
        end
        MODE_SAWTOOTH: begin
          level_next = (out_level == amp) ? '0 : level_up;
        end
        MODE_TRIANGLE: begin
          if (rising) begin
            level_next = level_up;
            if (level_up == amp) begin
              rising_next = 1'b0;
            end
          end else begin
            level_next = level_down;
            if (level_down == '0) begin
              rising_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_level <= '0;
      rising    <= 1'b1;
    end else begin
      out_level <= level_next;
      rising    <= rising_next;
    end
  end

endmodule

// ===== src/three_mode_waveform_generator_unit.sv =====
// Three-mode waveform generator: square, sawtooth and triangle.
//
// Each item on in_item is one tick of the base clock and carries the gate
// bit. A prescaler counts ticks up to the prescale register, a period counter
// counts prescaler wraps up to the period register, and when the period
// counter wraps on a tick with the gate high the output level takes one step.
// Each accepted item produces exactly one result item on out_item holding the
// level after that tick and a flag that tells whether it stepped.
// Configuration is to be written through cfg_we/cfg_idx/cfg_data by the user
// only while no item is in flight; the block itself does not enforce this.
// The result is held in the output register in the cycle after the item is
// accepted. One item is accepted per cycle while the receiver takes results;
// the counters and the level update in the same cycle that the item is taken.
// When the receiver stalls, the result stays in the output register and
// in_item.ready drops until it is taken; nothing is lost.
// Reset clears the counters and the level, sets the triangle direction to
// rising, and loads the register defaults (square, full amplitude, prescale
// and period zero).
module three_mode_waveform_generator_unit #(
  parameter int LEVEL_BITS = tmwg_pkg::LEVEL_BITS_DEF,
  parameter int TIMER_BITS = tmwg_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tmwg_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [tmwg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  tmwg_in_if.sink                            in_item,
  tmwg_out_if.source                         out_item
);
  import tmwg_pkg::*;

  cfg_t                  cfg;
  logic                  accept;
  logic                  period_wrap;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  step;

  logic                  out_valid;
  logic [LEVEL_BITS-1:0] out_level;
  logic                  out_stepped;

  // Take an item whenever the output register is free or being emptied.
  assign in_item.ready = !out_valid || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  tmwg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tmwg_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .cfg         (cfg),
    .period_wrap (period_wrap)
  );

  tmwg_shaper #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_shaper (
    .clk         (clk),
    .rst         (rst),
    .period_wrap (period_wrap),
    .gate        (in_item.gate),
    .cfg         (cfg),
    .level_next  (level_next),
    .step        (step)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level   <= level_next;
      out_stepped <= step;
    end
  end

  assign out_item.valid   = out_valid;
  assign out_item.level   = out_level;
  assign out_item.stepped = out_stepped;

endmodule

// ===== src/tmwg_checker.sv =====
module tmwg_checker #(
  parameter int LEVEL_BITS = tmwg_pkg::LEVEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_gate,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] out_level,
  input logic                  out_stepped
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Every accepted item shows its result in the next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item gave no result");

  // A tick with the gate low never steps the waveform.
  a_gate_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_gate) |=> !out_stepped)
    else $error("step reported with gate low");

  // A stalled result keeps its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_level) && $stable(out_stepped))
    else $error("stalled result changed");

endmodule

bind three_mode_waveform_generator_unit tmwg_checker #(
  .LEVEL_BITS (LEVEL_BITS)
) u_tmwg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .in_gate     (in_item.gate),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .out_level   (out_item.level),
  .out_stepped (out_item.stepped)
);
